### rtl/core/ab_nal_pkg.sv
package ab_nal_pkg;

    // Most result beats one stream byte can cause
    localparam int MaxBeats = 5;
    localparam int CntW     = $clog2(MaxBeats + 1);

    // Bytes that make up a start code
    localparam logic [7:0] ZeroByte = 8'h00;
    localparam logic [7:0] OneByte  = 8'h01;

    // Zero run length at which a zero pushes the oldest pending zero out
    localparam logic [1:0] ZeroRunFull = 2'd3;

    typedef logic [CntW-1:0] t_cnt;

    // One result beat
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       err;
    } t_beat;

    // All beats caused by one stream byte, beat 0 delivered first
    typedef struct packed {
        t_beat [MaxBeats-1:0] beat;
        t_cnt                 count;
    } t_run;

endpackage

### rtl/core/annex_b_nal_splitter_core.sv
// Annex B start code parser: takes one stream byte per beat and returns the
// payload bytes of each NAL unit, with nal_first on the header byte and
// nal_last on the final byte; leading bytes before the first start code are
// dropped and a buffer with no start code gives one no_start_code beat. A
// byte is accepted in every cycle as long as each byte causes at most one
// result beat and the output is not stalled; a byte may cause up to 5 beats
// (after a zero run and at buffer end), and the input stalls while more than
// one beat of that run remains in the five-entry result buffer or its last
// beat is stalled. An input beat passes through the input register and then
// the result buffer before its first result beat. run_last marks the last
// beat caused by one input byte.
module annex_b_nal_splitter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_stream_byte,
    input  logic       i_buffer_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_nal_first,
    output logic       o_nal_last,
    output logic       o_no_start_code,
    output logic       o_run_last
);
    import ab_nal_pkg::*;

    t_beat r_beat [MaxBeats];
    t_cnt  r_cnt;

    logic  deliver;
    logic  take;
    logic  load;
    t_run  run;

    assign o_valid = (r_cnt != t_cnt'(0));
    assign deliver = o_valid && !i_stall;
    assign take    = (r_cnt == t_cnt'(0)) || ((r_cnt == t_cnt'(1)) && deliver);

    ab_nal_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_stream_byte (i_stream_byte),
        .i_buffer_end  (i_buffer_end),
        .i_take        (take),
        .o_stall       (o_stall),
        .o_load        (load),
        .o_run         (run)
    );

    // Result buffer: load a whole run, shift one beat out per delivery
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= t_cnt'(0);
        end else if (load) begin
            r_cnt <= run.count;
        end else if (deliver) begin
            r_cnt <= r_cnt - t_cnt'(1);
        end
        if (load) begin
            for (int k = 0; k < MaxBeats; k++) begin
                r_beat[k] <= run.beat[k];
            end
        end else if (deliver) begin
            for (int k = 0; k < MaxBeats - 1; k++) begin
                r_beat[k] <= r_beat[k+1];
            end
        end
    end

    assign o_payload_byte  = r_beat[0].data;
    assign o_nal_first     = r_beat[0].first;
    assign o_nal_last      = r_beat[0].last;
    assign o_no_start_code = r_beat[0].err;
    assign o_run_last      = (r_cnt == t_cnt'(1));

endmodule

### rtl/core/ab_nal_parse.sv
module ab_nal_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_stream_byte,
    input  logic            i_buffer_end,
    input  logic            i_take,
    output logic            o_stall,
    output logic            o_load,
    output ab_nal_pkg::t_run o_run
);
    import ab_nal_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    logic       r_synced, n_synced;
    logic [7:0] r_held,   n_held;
    logic       r_hv,     n_hv;
    logic [1:0] r_zc,     n_zc;
    logic       r_af,     n_af;

    logic       step;
    t_run       run;

    assign step    = r_in_valid && i_take;
    assign o_stall = r_in_valid && !i_take;
    assign o_load  = step;
    assign o_run   = run;

    // Input register: load a new beat whenever the slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall) begin
            r_in_byte <= i_stream_byte;
            r_in_end  <= i_buffer_end;
        end
    end

    // Work out the beats of this byte and the state it leaves
    always_comb begin
        logic       is0;
        logic       is1;
        logic       restart;
        logic       e_held;
        logic [1:0] n_z;
        logic       m_synced;
        logic [7:0] m_held;
        logic       m_hv;
        logic [1:0] m_zc;
        logic       tail_held;
        logic       mark_last;
        logic       err;
        t_cnt       p2;
        t_cnt       cnt;

        is0       = (r_in_byte == ZeroByte);
        is1       = (r_in_byte == OneByte);
        restart   = 1'b0;
        e_held    = 1'b0;
        n_z       = 2'd0;
        m_synced  = r_synced;
        m_held    = r_held;
        m_hv      = r_hv;
        m_zc      = r_zc;
        tail_held = 1'b0;
        mark_last = 1'b0;
        err       = 1'b0;

        if (!r_synced) begin
            // Hunt for the first start code, drop everything else
            if (is0) begin
                m_zc = (r_zc == ZeroRunFull) ? ZeroRunFull : r_zc + 2'd1;
            end else if (is1 && r_zc[1]) begin
                m_synced = 1'b1;
                m_zc     = 2'd0;
                m_hv     = 1'b0;
                restart  = 1'b1;
            end else begin
                m_zc = 2'd0;
            end
        end else if (is0) begin
            // Hold zeros; a fourth one pushes the oldest into the payload
            if (r_zc != ZeroRunFull) begin
                m_zc = r_zc + 2'd1;
            end else begin
                e_held = r_hv;
                m_held = ZeroByte;
                m_hv   = 1'b1;
            end
        end else if (is1 && r_zc[1]) begin
            // Start code: close the current unit
            e_held    = r_hv;
            mark_last = 1'b1;
            m_hv      = 1'b0;
            m_zc      = 2'd0;
            restart   = 1'b1;
        end else begin
            // Ordinary byte: pending zeros were payload after all
            e_held = r_hv;
            n_z    = r_zc;
            m_zc   = 2'd0;
            m_held = r_in_byte;
            m_hv   = 1'b1;
        end

        p2  = t_cnt'(e_held) + t_cnt'(n_z);
        cnt = p2;

        // Flush at buffer end, or report a buffer with no start code
        if (r_in_end) begin
            if (m_synced) begin
                tail_held = m_hv;
                cnt       = p2 + t_cnt'(tail_held) + t_cnt'(m_zc);
                mark_last = 1'b1;
            end else begin
                err = 1'b1;
                cnt = t_cnt'(1);
            end
        end

        for (int k = 0; k < MaxBeats; k++) begin
            if (k == 0 && e_held) begin
                run.beat[k].data = r_held;
            end else if (tail_held && t_cnt'(k) == p2) begin
                run.beat[k].data = m_held;
            end else begin
                run.beat[k].data = ZeroByte;
            end
            run.beat[k].first = (k == 0) && r_af && !err;
            run.beat[k].last  = mark_last && (t_cnt'(k) == cnt - t_cnt'(1));
            run.beat[k].err   = (k == 0) && err;
        end
        run.count = cnt;

        // Next state; buffer end returns to the reset state
        if (r_in_end) begin
            n_synced = 1'b0;
            n_held   = m_held;
            n_hv     = 1'b0;
            n_zc     = 2'd0;
            n_af     = 1'b1;
        end else begin
            n_synced = m_synced;
            n_held   = m_held;
            n_hv     = m_hv;
            n_zc     = m_zc;
            if (restart) begin
                n_af = 1'b1;
            end else if (cnt != t_cnt'(0)) begin
                n_af = 1'b0;
            end else begin
                n_af = r_af;
            end
        end
    end

    // Parser state: advance once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced <= 1'b0;
            r_hv     <= 1'b0;
            r_zc     <= 2'd0;
            r_af     <= 1'b1;
        end else if (step) begin
            r_synced <= n_synced;
            r_hv     <= n_hv;
            r_zc     <= n_zc;
            r_af     <= n_af;
        end
        if (step) begin
            r_held <= n_held;
        end
    end

endmodule

### rtl/core/ab_nal_checker.sv
module ab_nal_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_payload_byte,
    input logic       o_nal_first,
    input logic       o_nal_last,
    input logic       o_no_start_code,
    input logic       o_run_last
);

    // A stalled beat stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat withdrawn under stall");

    // A stalled beat keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_payload_byte) && $stable(o_nal_first)
            && $stable(o_nal_last) && $stable(o_no_start_code) && $stable(o_run_last))
        else $error("stalled result beat changed");

    // Nothing follows the end of a unit within the same run
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_nal_last || o_no_start_code) |-> o_run_last)
        else $error("beat follows unit end within one run");

    // A run that is not finished goes on in the next cycle
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_run_last |=> o_valid)
        else $error("run broken off before its last beat");

endmodule

bind annex_b_nal_splitter_core ab_nal_checker u_chk (.*);
